// ===== rtl/arqt_pkg.sv =====
// Shared types, sizes and codes for the ARQ retransmit tracker.
package arqt_pkg;

    localparam int UNACKED_SLOTS = 16;
    localparam int PENDING_DEPTH = 128;
    localparam int SEEN_SLOTS    = 64;

    localparam int ID_W       = 16;
    localparam int KIND_W     = 2;
    localparam int EVENT_W    = 4;
    localparam int SLOT_W     = 4;
    localparam int PEND_W     = 8;
    localparam int TIMEOUT_W  = 8;
    localparam int SLOT_IDX_W = (UNACKED_SLOTS > 1) ? $clog2(UNACKED_SLOTS) : 1;
    localparam int SEEN_IDX_W = (SEEN_SLOTS > 1) ? $clog2(SEEN_SLOTS) : 1;

    typedef logic [ID_W-1:0]       id_t;
    typedef logic [SLOT_W-1:0]     slot_field_t;
    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
    typedef logic [SEEN_IDX_W-1:0] seen_idx_t;
    typedef logic [PEND_W-1:0]     pend_t;
    typedef logic [TIMEOUT_W-1:0]  timeout_t;
    typedef logic [EVENT_W-1:0]    event_code_t;
    typedef logic [KIND_W-1:0]     kind_code_t;

    localparam kind_code_t KIND_SEND = 2'd0;
    localparam kind_code_t KIND_ACK  = 2'd1;
    localparam kind_code_t KIND_DATA = 2'd2;
    localparam kind_code_t KIND_TICK = 2'd3;

    localparam event_code_t EV_QUEUED  = 4'd0;
    localparam event_code_t EV_REJECT  = 4'd1;
    localparam event_code_t EV_ACK_OK  = 4'd2;
    localparam event_code_t EV_ACK_UNK = 4'd3;
    localparam event_code_t EV_NEW     = 4'd4;
    localparam event_code_t EV_DUP     = 4'd5;
    localparam event_code_t EV_TX      = 4'd6;
    localparam event_code_t EV_RETX    = 4'd7;
    localparam event_code_t EV_DONE    = 4'd8;

    localparam timeout_t TIMEOUT_RESET = 8'd2;
    localparam id_t      FIRST_ID      = 16'd1;

    // One unacked table slot.
    typedef struct packed {
        logic valid;
        id_t  msg_id;
        id_t  stamp;
    } entry_t;

    // Shift control for the slot ring.
    typedef struct packed {
        logic fwd;
        logic bwd;
    } shift_t;

endpackage

// ===== rtl/arqt_if.sv =====
// Valid/ready channel interfaces for the command and event streams.
interface arqt_cmd_if;
    logic                   valid;
    logic                   ready;
    arqt_pkg::kind_code_t   kind;
    arqt_pkg::id_t          msg_id;

    modport source (output valid, output kind, output msg_id, input ready);
    modport sink (input valid, input kind, input msg_id, output ready);
endinterface

interface arqt_evt_if;
    logic                   valid;
    logic                   ready;
    arqt_pkg::event_code_t  event_res;
    arqt_pkg::id_t          msg_id_res;
    arqt_pkg::slot_field_t  slot;
    logic                   last;

    modport source (output valid, output event_res, output msg_id_res, output slot,
                    output last, input ready);
    modport sink (input valid, input event_res, input msg_id_res, input slot,
                  input last, output ready);
endinterface

// ===== rtl/arqt_cell.sv =====
// One slot cell of the unacked ring: holds an entry, or takes a neighbor's.
module arqt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  arqt_pkg::shift_t  shift,
    input  arqt_pkg::entry_t  from_left,
    input  arqt_pkg::entry_t  from_right,
    output arqt_pkg::entry_t  q
);

    logic             valid_reg;
    arqt_pkg::id_t    msg_id_reg;
    arqt_pkg::id_t    stamp_reg;
    arqt_pkg::entry_t entry_next;

    assign q = '{valid: valid_reg, msg_id: msg_id_reg, stamp: stamp_reg};

    always_comb
    begin
        if (shift.fwd)
        begin
            entry_next = from_right;
        end
        else if (shift.bwd)
        begin
            entry_next = from_left;
        end
        else
        begin
            entry_next = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_id_reg <= entry_next.msg_id;
        stamp_reg  <= entry_next.stamp;
    end

endmodule

// ===== rtl/arqt_chain.sv =====
// Ring of slot cells that rotates one place a cycle in either direction, as its shift input selects.
module arqt_chain (
    input  logic              clk,
    input  logic              rst_n,
    input  arqt_pkg::shift_t  shift,
    input  arqt_pkg::entry_t  inject,
    output arqt_pkg::entry_t  head_fwd,
    output arqt_pkg::entry_t  head_bwd
);

    arqt_pkg::entry_t cells [arqt_pkg::UNACKED_SLOTS];

    // Forward shift moves every entry one cell down and feeds the top cell
    // from the injected entry; backward shift is the mirror image.
    for (genvar i = 0; i < arqt_pkg::UNACKED_SLOTS; i++)
    begin : g_cell
        arqt_pkg::entry_t left_in;
        arqt_pkg::entry_t right_in;

        if (i == 0)
        begin : g_first
            assign left_in = inject;
        end
        else
        begin : g_mid_l
            assign left_in = cells[i-1];
        end

        if (i == arqt_pkg::UNACKED_SLOTS - 1)
        begin : g_last
            assign right_in = inject;
        end
        else
        begin : g_mid_r
            assign right_in = cells[i+1];
        end

        arqt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (shift),
            .from_left  (left_in),
            .from_right (right_in),
            .q          (cells[i])
        );
    end

    assign head_fwd = cells[0];
    assign head_bwd = cells[arqt_pkg::UNACKED_SLOTS-1];

endmodule

// ===== rtl/arq_retransmit_tracker.sv =====
// Top level of the ARQ retransmit tracker: control, queue counters and seen-id table.
//
//  channel   dir   handshake        payload
//  cmd       in    valid / ready    kind, msg_id
//  evt       out   valid / ready    event_res, msg_id_res, slot, last
//  cfg       in    cfg_wr_en        cfg_wr_data (timeout in ticks)
//
// A send request or a data item gives one result from its result state. An ack
// walks all 16 slots of the ring once in the ack search, then gives its result.
// A tick makes one forward walk of the ring for retransmissions and one backward
// walk for new transmissions, then gives the done result.
// Reset clears all valid bits at once, so no clearing pass is needed.
// A stalled event output freezes the tick walks in place until the result is taken.
module arq_retransmit_tracker (
    input  logic                clk,
    input  logic                rst_n,
    arqt_cmd_if.sink            cmd,
    arqt_evt_if.source          evt,
    input  logic                cfg_wr_en,
    input  arqt_pkg::timeout_t  cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_ACK_WALK,
        S_ACK_RES,
        S_DATA,
        S_RETX_WALK,
        S_TX_WALK,
        S_DONE
    } state_t;

    localparam arqt_pkg::slot_idx_t LAST_STEP =
        arqt_pkg::slot_idx_t'(arqt_pkg::UNACKED_SLOTS - 1);

    state_t               state_reg;
    arqt_pkg::slot_idx_t  step_reg;
    logic                 found_reg;
    arqt_pkg::slot_idx_t  hit_reg;
    arqt_pkg::id_t        id_reg;
    arqt_pkg::pend_t      pending_reg;
    arqt_pkg::id_t        next_id_reg;
    arqt_pkg::id_t        tick_reg;
    arqt_pkg::timeout_t   timeout_reg;

    logic                   out_valid_reg;
    arqt_pkg::event_code_t  out_event_reg;
    arqt_pkg::id_t          out_id_reg;
    arqt_pkg::slot_field_t  out_slot_reg;
    logic                   out_last_reg;

    // The seen-id table: valid bits in flops, ids in a memory with a registered read.
    logic [arqt_pkg::SEEN_SLOTS-1:0] seen_valid_reg;
    arqt_pkg::id_t                   seen_mem [arqt_pkg::SEEN_SLOTS];
    arqt_pkg::id_t                   seen_rd_reg;

    arqt_pkg::shift_t  shift;
    arqt_pkg::entry_t  inject;
    arqt_pkg::entry_t  head_fwd;
    arqt_pkg::entry_t  head_bwd;

    logic                   accept;
    logic                   out_free;
    logic                   emit;
    arqt_pkg::event_code_t  emit_event;
    arqt_pkg::id_t          emit_id;
    arqt_pkg::slot_field_t  emit_slot;
    logic                   emit_last;
    logic                   ack_hit;
    logic                   retx_due;
    logic                   tx_fill;
    arqt_pkg::id_t          waited;
    arqt_pkg::id_t          tx_id;
    arqt_pkg::seen_idx_t    seen_idx;
    logic                   seen_dup;
    logic                   queue_full;

    arqt_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .inject   (inject),
        .head_fwd (head_fwd),
        .head_bwd (head_bwd)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    // A new result can be loaded when the output register is empty or drains now.
    assign out_free = !out_valid_reg || evt.ready;

    assign evt.valid      = out_valid_reg;
    assign evt.event_res  = out_event_reg;
    assign evt.msg_id_res = out_id_reg;
    assign evt.slot       = out_slot_reg;
    assign evt.last       = out_last_reg;

    // Waiting time of the slot at the forward head, modulo the id width.
    assign waited   = tick_reg - head_fwd.stamp;
    assign retx_due = head_fwd.valid && (waited >= arqt_pkg::id_t'(timeout_reg));
    assign ack_hit  = !found_reg && head_fwd.valid && (head_fwd.msg_id == id_reg);
    // The oldest pending id sits pending_count below the next id to issue.
    assign tx_id    = next_id_reg - arqt_pkg::id_t'(pending_reg);
    assign tx_fill  = !head_bwd.valid && (pending_reg != '0);

    assign seen_idx   = id_reg[arqt_pkg::SEEN_IDX_W-1:0];
    assign seen_dup   = seen_valid_reg[seen_idx] && (seen_rd_reg == id_reg);
    assign queue_full = (pending_reg >= arqt_pkg::pend_t'(arqt_pkg::PENDING_DEPTH));

    always_comb
    begin
        shift      = '{fwd: 1'b0, bwd: 1'b0};
        inject     = head_fwd;
        emit       = 1'b0;
        emit_event = arqt_pkg::EV_DONE;
        emit_id    = id_reg;
        emit_slot  = '0;
        emit_last  = 1'b1;
        case (state_reg)
            S_SEND:
            begin
                emit       = out_free;
                emit_event = queue_full ? arqt_pkg::EV_REJECT : arqt_pkg::EV_QUEUED;
                emit_id    = next_id_reg;
            end
            S_ACK_WALK:
            begin
                // The first valid slot that holds the id loses its valid bit.
                shift.fwd = 1'b1;
                inject    = head_fwd;
                if (ack_hit)
                begin
                    inject.valid = 1'b0;
                end
            end
            S_ACK_RES:
            begin
                emit       = out_free;
                emit_event = found_reg ? arqt_pkg::EV_ACK_OK : arqt_pkg::EV_ACK_UNK;
                emit_slot  = found_reg ? arqt_pkg::slot_field_t'(hit_reg) : '0;
            end
            S_DATA:
            begin
                emit       = out_free;
                emit_event = seen_dup ? arqt_pkg::EV_DUP : arqt_pkg::EV_NEW;
            end
            S_RETX_WALK:
            begin
                // The forward head holds slot number step_reg.
                shift.fwd = out_free;
                inject    = head_fwd;
                if (retx_due)
                begin
                    inject.stamp = tick_reg;
                end
                emit       = out_free && retx_due;
                emit_event = arqt_pkg::EV_RETX;
                emit_id    = head_fwd.msg_id;
                emit_slot  = arqt_pkg::slot_field_t'(step_reg);
                emit_last  = 1'b0;
            end
            S_TX_WALK:
            begin
                // The backward head holds slot number LAST_STEP - step_reg, so free
                // slots are filled from the top down with the oldest ids first.
                shift.bwd = out_free;
                inject    = head_bwd;
                if (tx_fill)
                begin
                    inject = '{valid: 1'b1, msg_id: tx_id, stamp: tick_reg};
                end
                emit       = out_free && tx_fill;
                emit_event = arqt_pkg::EV_TX;
                emit_id    = tx_id;
                emit_slot  = arqt_pkg::slot_field_t'(LAST_STEP - step_reg);
                emit_last  = 1'b0;
            end
            S_DONE:
            begin
                emit       = out_free;
                emit_event = arqt_pkg::EV_DONE;
                emit_id    = tick_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Seen-id memory: read at the transfer of an item, written when new data arrives.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seen_rd_reg <= seen_mem[cmd.msg_id[arqt_pkg::SEEN_IDX_W-1:0]];
        end
        if ((state_reg == S_DATA) && out_free && !seen_dup)
        begin
            seen_mem[seen_idx] <= id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_valid_reg <= '0;
        end
        else if ((state_reg == S_DATA) && out_free && !seen_dup)
        begin
            seen_valid_reg[seen_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            hit_reg       <= '0;
            id_reg        <= '0;
            pending_reg   <= '0;
            next_id_reg   <= arqt_pkg::FIRST_ID;
            tick_reg      <= '0;
            timeout_reg   <= arqt_pkg::TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
            out_event_reg <= arqt_pkg::EV_QUEUED;
            out_id_reg    <= '0;
            out_slot_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_event_reg <= emit_event;
                out_id_reg    <= emit_id;
                out_slot_reg  <= emit_slot;
                out_last_reg  <= emit_last;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        id_reg    <= cmd.msg_id;
                        found_reg <= 1'b0;
                        step_reg  <= '0;
                        case (cmd.kind)
                            arqt_pkg::KIND_SEND: state_reg <= S_SEND;
                            arqt_pkg::KIND_ACK:  state_reg <= S_ACK_WALK;
                            arqt_pkg::KIND_DATA: state_reg <= S_DATA;
                            default:
                            begin
                                // The tick count advances before the slots are examined.
                                tick_reg  <= tick_reg + 1'b1;
                                state_reg <= S_RETX_WALK;
                            end
                        endcase
                    end
                end
                S_SEND:
                begin
                    if (out_free)
                    begin
                        if (!queue_full)
                        begin
                            pending_reg <= pending_reg + 1'b1;
                            next_id_reg <= next_id_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_ACK_WALK:
                begin
                    if (ack_hit)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= step_reg;
                    end
                    if (step_reg == LAST_STEP)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_ACK_RES;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_ACK_RES, S_DATA, S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RETX_WALK:
                begin
                    if (out_free)
                    begin
                        if (step_reg == LAST_STEP)
                        begin
                            step_reg  <= '0;
                            state_reg <= S_TX_WALK;
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                S_TX_WALK:
                begin
                    if (out_free)
                    begin
                        if (tx_fill)
                        begin
                            pending_reg <= pending_reg - 1'b1;
                        end
                        if (step_reg == LAST_STEP)
                        begin
                            step_reg  <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/arqt_checker.sv =====
// Port-level assertions for the ARQ retransmit tracker and their bind.
module arqt_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  logic                   cmd_ready,
    input  logic                   evt_valid,
    input  logic                   evt_ready,
    input  arqt_pkg::event_code_t  evt_event_res,
    input  arqt_pkg::id_t          evt_msg_id_res,
    input  arqt_pkg::slot_field_t  evt_slot,
    input  logic                   evt_last
);

    // A stalled result stays on the port unchanged.
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt_event_res)
            && $stable(evt_msg_id_res) && $stable(evt_slot) && $stable(evt_last))
        else $error("event changed while stalled");

    // Transmit and retransmit results are never the final result of an item.
    a_walk_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt_event_res == arqt_pkg::EV_TX || evt_event_res == arqt_pkg::EV_RETX)
            |-> !evt_last)
        else $error("transmit result marked last");

    // Every other result closes its item.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_event_res != arqt_pkg::EV_TX && evt_event_res != arqt_pkg::EV_RETX
            |-> evt_last)
        else $error("final result not marked last");

    // Only slot-related results carry a nonzero slot number.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_slot != '0 |-> (evt_event_res == arqt_pkg::EV_TX
            || evt_event_res == arqt_pkg::EV_RETX || evt_event_res == arqt_pkg::EV_ACK_OK))
        else $error("slot set on a result without a slot");

    // No new item is taken while a multi-result item is still in flight.
    a_no_accept_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_last |-> !(cmd_valid && cmd_ready))
        else $error("item accepted in the middle of a tick");

endmodule

bind arq_retransmit_tracker arqt_checker u_arqt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .evt_valid      (evt.valid),
    .evt_ready      (evt.ready),
    .evt_event_res  (evt.event_res),
    .evt_msg_id_res (evt.msg_id_res),
    .evt_slot       (evt.slot),
    .evt_last       (evt.last)
);
